### sv/stsmc_pkg.sv
`timescale 1ns / 1ps
package stsmc_pkg;

   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 24;

   localparam logic [CsrIndexW-1:0] CSR_BOUNDARY_WIDTH = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_ROOT_GAIN      = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_INTEGRAL_STEP  = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_INTEGRAL_MAX   = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_INTEGRAL_MIN   = 3'd4;
   localparam logic [CsrIndexW-1:0] CSR_DRIVE_MAX      = 3'd5;
   localparam logic [CsrIndexW-1:0] CSR_DRIVE_MIN      = 3'd6;

   localparam int MulAW = 32;
   localparam int MulBW = 17;
   localparam int MulPW = MulAW + MulBW;

   typedef struct packed {
      logic signed [15:0] reference;
      logic signed [15:0] feedback;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               integral_frozen;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DS_START,
      ST_DS_WAIT,
      ST_M1_START,
      ST_M1_WAIT,
      ST_M2_START,
      ST_M2_WAIT,
      ST_M3_START,
      ST_M3_WAIT,
      ST_INTEG,
      ST_ILIM,
      ST_SUM,
      ST_CLAMP,
      ST_DONE
   } stsmc_state_type;

endpackage

### sv/stsmc_div.sv
`timescale 1ns / 1ps
module stsmc_div import stsmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic [14:0] quotient,
   output logic        done
);

   logic [15:0] rem_ff, rem_in;
   logic [14:0] quo_ff, quo_in;
   logic [15:0] div_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [16:0] shifted;
   logic        fits;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, div_ff};
      rem_in  = fits ? 16'(shifted - {1'b0, div_ff}) : shifted[15:0];
      quo_in  = {quo_ff[13:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (cnt_ff == 4'd14) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend;
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

### sv/stsmc_sqrt.sv
`timescale 1ns / 1ps
module stsmc_sqrt import stsmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] magnitude,
   output logic [15:0] root,
   output logic        done
);

   logic [31:0] rad_ff;
   logic [17:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [19:0] partial;
   logic [19:0] trial;
   logic        fits;

   always_comb begin
      partial = {rem_ff, rad_ff[31:30]};
      trial   = {2'b00, root_ff, 2'b01};
      fits    = partial >= trial;
      rem_in  = fits ? 18'(partial - trial) : partial[17:0];
      root_in = {root_ff[14:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {magnitude, 16'h0000};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[29:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

### sv/stsmc_mul.sv
`timescale 1ns / 1ps
module stsmc_mul import stsmc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MulAW-1:0] mcand,
   input  logic [MulBW-1:0] mplier,
   output logic [MulPW-1:0] product,
   output logic             done
);

   logic [MulAW-1:0] a_ff;
   logic [MulAW:0]   hi_ff, hi_in;
   logic [MulBW-1:0] lo_ff, lo_in;
   logic [MulAW:0]   acc;
   logic [4:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   always_comb begin
      acc   = hi_ff + (lo_ff[0] ? {1'b0, a_ff} : '0);
      hi_in = {1'b0, acc[MulAW:1]};
      lo_in = {acc[0], lo_ff[MulBW-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(MulBW - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= mcand;
         hi_ff <= '0;
         lo_ff <= mplier;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign product = {hi_ff[MulAW-1:0], lo_ff};
   assign done    = done_ff;

endmodule

### sv/super_twisting_sliding_mode_controller.sv
// Channel   Ports                        Word
// input     req_valid/req_ready          req_data: reference, feedback
// result    rsp_valid/rsp_ready          rsp_data: drive, integral_frozen
// config    csr_we/csr_index/csr_wdata   one register per write, no wait
// Each word runs through the 16-step square root and then three passes through the
// shared bit-serial multiplier.
// A new word is accepted while the previous result waits in the output register.
// Reset is synchronous and restores the register defaults and clears the state.
`timescale 1ns / 1ps
module super_twisting_sliding_mode_controller import stsmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   stsmc_state_type state_ff, state_in;

   logic [15:0]        boundary_ff;
   logic [15:0]        gain_ff;
   logic [23:0]        step_ff;
   logic signed [15:0] imax_ff, imin_ff, dmax_ff, dmin_ff;

   logic signed [16:0] prev_sat_ff;
   logic signed [31:0] integ_ff;
   logic               frozen_ff;

   logic               neg_ff;
   logic [15:0]        mag_ff;
   logic               lin_ff;
   logic [15:0]        sat_mag_ff;
   logic signed [16:0] sat_ff;
   logic [15:0]        sqrt_ff;
   logic [31:0]        prod_ff;
   logic signed [33:0] nl_ff;
   logic signed [26:0] delta_ff;
   logic signed [33:0] inew_ff;
   logic signed [35:0] sum_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic               out_free;
   logic               ds_start, mul_start;
   logic [15:0]        bnd;
   logic signed [16:0] err;
   logic signed [17:0] ssum;
   logic [16:0]        smag;
   logic [MulAW-1:0]   mul_a;
   logic [MulBW-1:0]   mul_b;
   logic [MulPW-1:0]   mul_p;
   logic               mul_done, div_done, sqrt_done;
   logic [14:0]        quo;
   logic [15:0]        root;
   logic signed [33:0] imax34, imin34, integ34;
   logic signed [35:0] dmax36, dmin36, rounded;
   logic               opposite, strictly_between;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign bnd      = (boundary_ff == 16'd0) ? 16'd1 : boundary_ff;
   assign err      = {req_data.reference[15], req_data.reference}
                     - {req_data.feedback[15], req_data.feedback};
   assign ssum     = {sat_ff[16], sat_ff} + {prev_sat_ff[16], prev_sat_ff};
   assign smag     = ssum[17] ? 17'(-ssum) : ssum[16:0];
   assign imax34   = {{2{imax_ff[15]}}, imax_ff, 16'h0000};
   assign imin34   = {{2{imin_ff[15]}}, imin_ff, 16'h0000};
   assign integ34  = {{2{integ_ff[31]}}, integ_ff};
   assign dmax36   = {{4{dmax_ff[15]}}, dmax_ff, 16'h0000};
   assign dmin36   = {{4{dmin_ff[15]}}, dmin_ff, 16'h0000};
   assign rounded  = sum_ff + 36'sd32768;
   assign opposite = (!sat_ff[16] && sat_ff != 17'sd0 && integ_ff < 32'sd0)
                     || (sat_ff[16] && integ_ff > 32'sd0);
   assign strictly_between = (integ34 < imax34) && (integ34 > imin34);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_DS_START;
         ST_DS_START: state_in = ST_DS_WAIT;
         ST_DS_WAIT:  if (sqrt_done) state_in = ST_M1_START;
         ST_M1_START: state_in = ST_M1_WAIT;
         ST_M1_WAIT:  if (mul_done) state_in = ST_M2_START;
         ST_M2_START: state_in = ST_M2_WAIT;
         ST_M2_WAIT:  if (mul_done) state_in = ST_M3_START;
         ST_M3_START: state_in = ST_M3_WAIT;
         ST_M3_WAIT:  if (mul_done) state_in = ST_INTEG;
         ST_INTEG: begin
            if (step_ff != 24'd0 && !frozen_ff) state_in = ST_ILIM;
            else state_in = ST_SUM;
         end
         ST_ILIM:     state_in = ST_SUM;
         ST_SUM:      state_in = ST_CLAMP;
         ST_CLAMP:    state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ds_start  = 1'b0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_IDLE:     req_ready = !reset;
         ST_DS_START: ds_start = 1'b1;
         ST_M1_START: begin
            mul_start = 1'b1;
            mul_a     = {16'h0000, gain_ff};
            mul_b     = {1'b0, sqrt_ff};
         end
         ST_M2_START: begin
            mul_start = 1'b1;
            mul_a     = prod_ff;
            mul_b     = {1'b0, sat_mag_ff};
         end
         ST_M3_START: begin
            mul_start = 1'b1;
            mul_a     = {8'h00, step_ff};
            mul_b     = smag;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   stsmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ds_start),
      .dividend (mag_ff),
      .divisor  (bnd),
      .quotient (quo),
      .done     (div_done)
   );

   stsmc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .start     (ds_start),
      .magnitude (mag_ff),
      .root      (root),
      .done      (sqrt_done)
   );

   stsmc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .product (mul_p),
      .done    (mul_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         boundary_ff  <= 16'd1024;
         gain_ff      <= 16'd256;
         step_ff      <= 24'd0;
         imax_ff      <= 16'sh7FFF;
         imin_ff      <= 16'sh8000;
         dmax_ff      <= 16'sh7FFF;
         dmin_ff      <= 16'sh8000;
         prev_sat_ff  <= '0;
         integ_ff     <= '0;
         frozen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BOUNDARY_WIDTH: boundary_ff <= csr_wdata[15:0];
               CSR_ROOT_GAIN:      gain_ff     <= csr_wdata[15:0];
               CSR_INTEGRAL_STEP:  step_ff     <= csr_wdata;
               CSR_INTEGRAL_MAX:   imax_ff     <= csr_wdata[15:0];
               CSR_INTEGRAL_MIN:   imin_ff     <= csr_wdata[15:0];
               CSR_DRIVE_MAX:      dmax_ff     <= csr_wdata[15:0];
               CSR_DRIVE_MIN:      dmin_ff     <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_INTEG && step_ff != 24'd0 && frozen_ff
             && (opposite || strictly_between))
            frozen_ff <= 1'b0;
         if (state_ff == ST_ILIM) begin
            if (inew_ff > imax34) begin
               integ_ff  <= imax34[31:0];
               frozen_ff <= 1'b1;
            end else if (inew_ff < imin34) begin
               integ_ff  <= imin34[31:0];
               frozen_ff <= 1'b1;
            end else begin
               integ_ff <= inew_ff[31:0];
            end
         end
         if (state_ff == ST_SUM) prev_sat_ff <= sat_ff;
         if (state_ff == ST_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= err[16];
         mag_ff <= err[16] ? 16'(-err) : err[15:0];
      end
      if (state_ff == ST_DS_START) lin_ff <= mag_ff < bnd;
      if (state_ff == ST_DS_WAIT && div_done) begin
         sat_mag_ff <= lin_ff ? {1'b0, quo} : 16'h8000;
         sat_ff     <= neg_ff ? -$signed({1'b0, (lin_ff ? {1'b0, quo} : 16'h8000)})
                              : $signed({1'b0, (lin_ff ? {1'b0, quo} : 16'h8000)});
      end
      if (state_ff == ST_DS_WAIT && sqrt_done) sqrt_ff <= root;
      if (state_ff == ST_M1_WAIT && mul_done) prod_ff <= mul_p[31:0];
      if (state_ff == ST_M2_WAIT && mul_done)
         nl_ff <= sat_ff[16] ? -$signed({2'b00, mul_p[46:15]})
                             : $signed({2'b00, mul_p[46:15]});
      if (state_ff == ST_M3_WAIT && mul_done)
         delta_ff <= ssum[17] ? -$signed({2'b00, mul_p[39:15]})
                              : $signed({2'b00, mul_p[39:15]});
      if (state_ff == ST_INTEG)
         inew_ff <= {{2{integ_ff[31]}}, integ_ff} + {{7{delta_ff[26]}}, delta_ff};
      if (state_ff == ST_SUM)
         sum_ff <= {{2{nl_ff[33]}}, nl_ff} + {{4{integ_ff[31]}}, integ_ff};
      if (state_ff == ST_CLAMP) begin
         if (sum_ff > dmax36) sum_ff <= dmax36;
         else if (sum_ff < dmin36) sum_ff <= dmin36;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_ff.drive           <= rounded[31:16];
         rsp_ff.integral_frozen <= frozen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
